### rtl/rcff_pkg.sv
`timescale 1ns / 1ps

package rcff_pkg;

  localparam int ID_W     = 16;
  localparam int FEAT_W   = 32;
  localparam int CLASS_W  = 8;
  localparam int CNT_W    = 17;
  localparam int FRAC_W   = 16;
  localparam int CFG_IDX_W = 8;

  // Long division: one quotient bit per step, quotient has CNT_W bits
  localparam int DIV_STEPS = CNT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 56;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_UPPER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_CLS = CFG_IDX_W'(2);

  typedef struct packed {
    logic accept;
    logic start_div;
    logic div_step;
    logic load_final;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/rcff_ctrl.sv
`timescale 1ns / 1ps

module rcff_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  rcff_pkg::dp_stat_t stat,
  output rcff_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_DIV,
    S_DONE
  } state_t;

  state_t                           state;
  logic [rcff_pkg::DIV_CNT_W-1:0]   step_cnt;

  assign in_ready       = (state == S_RUN) && stat.out_free;
  assign cmd.accept     = in_valid && in_ready;
  assign cmd.start_div  = cmd.accept && in_last;
  assign cmd.div_step   = (state == S_DIV);
  assign cmd.load_final = (state == S_DONE) && stat.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      step_cnt <= '0;
    end else begin
      unique case (state)
        S_RUN: begin
          step_cnt <= '0;
          if (cmd.start_div) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          step_cnt <= step_cnt + 1'b1;
          if (step_cnt == rcff_pkg::DIV_CNT_W'(rcff_pkg::DIV_STEPS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.load_final) begin
            state <= S_RUN;
          end
        end
        default: state <= S_RUN;
      endcase
    end
  end

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |=> (state == S_DIV) && !in_ready)
    else $error("item taken while division pending");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (step_cnt == '0) |-> ##(rcff_pkg::DIV_STEPS) (state == S_DONE))
    else $error("division did not take the expected steps");

endmodule

### rtl/rcff_dp.sv
`timescale 1ns / 1ps

module rcff_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  rcff_pkg::dp_cmd_t                  cmd,
  output rcff_pkg::dp_stat_t                 stat,
  input  logic                               cfg_wr,
  input  logic [rcff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcff_pkg::FEAT_W-1:0]        cfg_data,
  input  logic [rcff_pkg::ID_W-1:0]          sample_id,
  input  logic signed [rcff_pkg::FEAT_W-1:0] feature_value,
  input  logic [rcff_pkg::CLASS_W-1:0]       sample_class,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kept,
  output logic [rcff_pkg::ID_W-1:0]          kept_id,
  output logic                               run_done,
  output logic [rcff_pkg::CNT_W-1:0]         covered_count,
  output logic [rcff_pkg::CNT_W-1:0]         fidelity
);

  localparam int CW = rcff_pkg::CNT_W;

  logic signed [rcff_pkg::FEAT_W-1:0] threshold;
  logic                               keep_upper_side;
  logic [rcff_pkg::CLASS_W-1:0]       target_class;

  logic [CW-1:0] kept_cnt, agree_cnt, kept_cnt_next, agree_cnt_next;
  logic          keep, kept_inc, agree_inc;

  logic [CW:0]                  div_rem;
  logic [CW-1:0]                div_den;
  logic [CW-1:0]                div_quo;
  logic                         pend_kept;
  logic [rcff_pkg::ID_W-1:0]    pend_id;
  logic                         div_ge;
  logic [CW:0]                  div_sub;

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      keep_upper_side <= 1'b1;
      target_class    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        rcff_pkg::REG_THRESHOLD:  threshold       <= cfg_data;
        rcff_pkg::REG_KEEP_UPPER: keep_upper_side <= cfg_data[0];
        rcff_pkg::REG_TARGET_CLS: target_class    <= cfg_data[rcff_pkg::CLASS_W-1:0];
        default: ;
      endcase
    end
  end

  // Keep when the side test matches the configured side
  assign keep      = ((feature_value >= threshold) == keep_upper_side);
  assign kept_inc  = cmd.accept && keep && (kept_cnt != rcff_pkg::CNT_MAX);
  assign agree_inc = kept_inc && (sample_class == target_class)
                     && (agree_cnt != rcff_pkg::CNT_MAX);
  assign kept_cnt_next  = kept_cnt + CW'(kept_inc);
  assign agree_cnt_next = agree_cnt + CW'(agree_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_cnt  <= '0;
      agree_cnt <= '0;
    end else if (cmd.start_div) begin
      kept_cnt  <= '0;
      agree_cnt <= '0;
    end else begin
      kept_cnt  <= kept_cnt_next;
      agree_cnt <= agree_cnt_next;
    end
  end

  // Restoring division of agree * 2^16 by kept; agree <= kept, so the
  // first step needs no shift and the remainder stays below 2 * kept.
  assign div_ge  = (div_rem >= {1'b0, div_den});
  assign div_sub = div_ge ? (div_rem - {1'b0, div_den}) : div_rem;

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      div_rem   <= {1'b0, agree_cnt_next};
      div_den   <= kept_cnt_next;
      div_quo   <= '0;
      pend_kept <= keep;
      pend_id   <= keep ? sample_id : '0;
    end else if (cmd.div_step) begin
      div_rem <= {div_sub[CW-1:0], 1'b0};
      div_quo <= {div_quo[CW-2:0], div_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.accept) begin
      out_valid <= keep && !last_sample;
    end else if (cmd.load_final) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && !last_sample) begin
      kept          <= 1'b1;
      kept_id       <= sample_id;
      run_done      <= 1'b0;
      covered_count <= '0;
      fidelity      <= '0;
    end else if (cmd.load_final) begin
      kept          <= pend_kept;
      kept_id       <= pend_id;
      run_done      <= 1'b1;
      covered_count <= div_den;
      fidelity      <= (div_den == '0) ? '0 : div_quo;
    end
  end

  a_agree_le_kept: assert property (@(posedge clk) disable iff (rst)
    agree_cnt <= kept_cnt)
    else $error("agree count exceeds kept count");

  a_fid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done |-> fidelity <= (CW'(1) << rcff_pkg::FRAC_W))
    else $error("fidelity above one");

  a_empty_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_done && (covered_count == '0) |-> (fidelity == '0) && !kept)
    else $error("empty run reports nonzero fidelity");

endmodule

### rtl/rule_coverage_fidelity_filter_core.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake          | Payload
// s_axis   | in        | s_tvalid/s_tready  | s_tdata: id, value, class; s_tlast: last sample
// m_axis   | out       | m_tvalid/m_tready  | m_tdata: id, count, fidelity; m_tuser: kept;
//          |           |                    | m_tlast: run done
// cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A non-last item that is kept leaves its result in the output register.
// The last item of a run holds the input off through its 17 divider steps
// (one quotient bit each) and until the result is loaded once the output register is free.
// A stalled output holds the input off only while the output register is full.
// rst is synchronous: it clears counters and handshake state and restores
// threshold 0, upper side kept, target class 0.

module rule_coverage_fidelity_filter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [15:0] sample_id, [47:16] feature_value, [55:48] sample_class
  input  logic [rcff_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [15:0] kept_id, [32:16] covered_count, [49:33] fidelity, [55:50] zero
  output logic [rcff_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [0] kept
  output logic                                m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcff_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcff_pkg::FEAT_W-1:0]         cfg_data
);

  rcff_pkg::dp_cmd_t  cmd;
  rcff_pkg::dp_stat_t stat;

  logic [rcff_pkg::ID_W-1:0]  kept_id;
  logic [rcff_pkg::CNT_W-1:0] covered_count;
  logic [rcff_pkg::CNT_W-1:0] fidelity;

  assign cfg_ready = 1'b1;

  rcff_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rcff_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_id     (s_tdata[15:0]),
    .feature_value (s_tdata[47:16]),
    .sample_class  (s_tdata[55:48]),
    .last_sample   (s_tlast),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .kept          (m_tuser),
    .kept_id       (kept_id),
    .run_done      (m_tlast),
    .covered_count (covered_count),
    .fidelity      (fidelity)
  );

  assign m_tdata = {6'b0, fidelity, covered_count, kept_id};

endmodule

### bench/rcff_coverage_check.sv
`timescale 1ns / 1ps

module rcff_coverage_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  // [15:0] sample_id, [47:16] feature_value, [55:48] sample_class
  input  logic [rcff_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] kept_id, [32:16] covered_count, [49:33] fidelity, [55:50] zero
  input  logic [rcff_pkg::OUT_DATA_W-1:0]   m_tdata,
  // [0] kept
  input  logic                              m_tuser,
  input  logic                              m_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rcff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcff_pkg::FEAT_W-1:0]       cfg_data,
  output int                                pending,
  output int                                errors,
  output int                                results_seen
);

  localparam int ID_W    = rcff_pkg::ID_W;
  localparam int CNT_W   = rcff_pkg::CNT_W;
  localparam int FEAT_W  = rcff_pkg::FEAT_W;
  localparam int CLASS_W = rcff_pkg::CLASS_W;
  localparam int FRAC_W  = rcff_pkg::FRAC_W;
  localparam int OUT_W   = rcff_pkg::OUT_DATA_W;

  typedef struct packed {
    logic               kept;
    logic [ID_W-1:0]    kept_id;
    logic               run_done;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   fidelity;
  } coverage_result_t;

  logic signed [FEAT_W-1:0] rule_threshold;
  logic                     rule_upper;
  logic [CLASS_W-1:0]       rule_class;
  logic [CNT_W-1:0]         kept_tally;
  logic [CNT_W-1:0]         agree_tally;
  coverage_result_t         coverage_q[$];
  int                       err_count = 0;
  int                       seen_count = 0;

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    err_count++;
  endtask

  // Filter one sample, update the run tallies, and queue the result it causes
  task automatic filter_sample(input logic [ID_W-1:0] id,
                               input logic signed [FEAT_W-1:0] value,
                               input logic [CLASS_W-1:0] cls, input logic last);
    logic                        upper;
    logic                        keep;
    logic [CNT_W+FRAC_W-1:0]     ratio;
    coverage_result_t            res;
    upper = value >= rule_threshold;
    keep = upper == rule_upper;
    // saturated kept tally freezes both tallies
    if (keep && kept_tally != rcff_pkg::CNT_MAX) begin
      kept_tally++;
      if (cls == rule_class && agree_tally != rcff_pkg::CNT_MAX)
        agree_tally++;
    end
    if (keep || last) begin
      res = '0;
      res.kept = keep;
      res.kept_id = keep ? id : '0;
      if (last) begin
        res.run_done = 1'b1;
        res.count = kept_tally;
        if (kept_tally != '0) begin
          ratio = {agree_tally, {FRAC_W{1'b0}}} / kept_tally;
          res.fidelity = ratio[CNT_W-1:0];
        end
        kept_tally = '0;
        agree_tally = '0;
      end
      coverage_q = {coverage_q, res};
    end
  endtask

  always @(posedge clk) begin
    coverage_result_t want;
    if (rst) begin
      rule_threshold = '0;
      rule_upper = 1'b1;
      rule_class = '0;
      kept_tally = '0;
      agree_tally = '0;
      coverage_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen_count++;
        if (coverage_q.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, got tdata %0h kept %0b",
                   $time, m_tdata, m_tuser);
          err_count++;
        end else begin
          want = coverage_q.pop_front();
          if (m_tuser !== want.kept)
            note_mismatch("kept", want.kept, m_tuser);
          if (m_tdata[ID_W-1:0] !== want.kept_id)
            note_mismatch("kept_id", want.kept_id, m_tdata[ID_W-1:0]);
          if (m_tlast !== want.run_done)
            note_mismatch("run_done", want.run_done, m_tlast);
          if (m_tdata[ID_W +: CNT_W] !== want.count)
            note_mismatch("covered_count", want.count, m_tdata[ID_W +: CNT_W]);
          if (m_tdata[ID_W+CNT_W +: CNT_W] !== want.fidelity)
            note_mismatch("fidelity", want.fidelity, m_tdata[ID_W+CNT_W +: CNT_W]);
          if (m_tdata[OUT_W-1:ID_W+2*CNT_W] !== '0)
            note_mismatch("tdata padding", '0, m_tdata[OUT_W-1:ID_W+2*CNT_W]);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rcff_pkg::REG_THRESHOLD:  rule_threshold = cfg_data;
          rcff_pkg::REG_KEEP_UPPER: rule_upper = cfg_data[0];
          rcff_pkg::REG_TARGET_CLS: rule_class = cfg_data[CLASS_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        filter_sample(s_tdata[ID_W-1:0], $signed(s_tdata[ID_W +: FEAT_W]),
                      s_tdata[ID_W+FEAT_W +: CLASS_W], s_tlast);
    end
    pending <= coverage_q.size();
    errors <= err_count;
    results_seen <= seen_count;
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int ID_W       = rcff_pkg::ID_W;
  localparam int FEAT_W     = rcff_pkg::FEAT_W;
  localparam int CLASS_W    = rcff_pkg::CLASS_W;
  localparam int CFG_IDX_W  = rcff_pkg::CFG_IDX_W;
  localparam int IN_DATA_W  = rcff_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = rcff_pkg::OUT_DATA_W;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 32;     // divider steps plus output register
  localparam int STALL_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int HOLD_PHASE    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = rcff_pkg::REG_TARGET_CLS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = '1;
  localparam logic [FEAT_W-1:0]    FEAT_MIN      = {1'b1, {(FEAT_W-1){1'b0}}};
  localparam logic [FEAT_W-1:0]    FEAT_MAX      = {1'b0, {(FEAT_W-1){1'b1}}};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tlast = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [FEAT_W-1:0]      cfg_data = '0;

  logic                   hold_req = 1'b0;
  int                     burst_left = 0;
  int                     stall_cycles = 0;
  int                     pending;
  int                     errors;
  int                     results_seen;
  int                     items_sent = 0;
  int                     runs_sent = 0;
  int                     rule_count = 0;
  logic [FEAT_W-1:0]      cur_threshold = '0;
  logic [CLASS_W-1:0]     cur_class = '0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  rule_coverage_fidelity_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcff_coverage_check i_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .errors       (errors),
    .results_seen (results_seen)
  );

  task automatic send_sample(input logic [ID_W-1:0] id, input logic [FEAT_W-1:0] value,
                             input logic [CLASS_W-1:0] cls, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 3);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0)
      burst_left--;
    s_tdata <= {cls, value, id};
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!s_tready);
    items_sent++;
  endtask

  // Drop valid and wait until every result is in and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FEAT_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
  endtask

  task automatic set_rule(input logic [FEAT_W-1:0] thr, input logic upper,
                          input logic [CLASS_W-1:0] cls);
    logic [FEAT_W-1:0] junk;
    junk = $urandom;
    write_reg(rcff_pkg::REG_THRESHOLD, thr);
    // upper bits of the narrow registers carry noise
    write_reg(rcff_pkg::REG_KEEP_UPPER, {junk[FEAT_W-1:1], upper});
    write_reg(rcff_pkg::REG_TARGET_CLS, {junk[FEAT_W-1:CLASS_W], cls});
    cfg_valid <= 1'b0;
    cur_threshold = thr;
    cur_class = cls;
    rule_count++;
  endtask

  function automatic logic [FEAT_W-1:0] pick_value();
    logic [FEAT_W-1:0] delta;
    delta = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0:       pick_value = FEAT_MIN;
      1:       pick_value = FEAT_MAX;
      2, 3:    pick_value = cur_threshold + delta - 4;
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic logic [CLASS_W-1:0] pick_class();
    pick_class = ($urandom_range(0, 2) != 0) ? cur_class : CLASS_W'($urandom);
  endfunction

  function automatic logic [FEAT_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       pick_threshold = FEAT_MIN;
      1:       pick_threshold = FEAT_MAX;
      2, 3:    pick_threshold = FEAT_W'($urandom_range(0, 1 << 20)) - (1 << 19);
      default: pick_threshold = $urandom;
    endcase
  endfunction

  task automatic send_run(input int len);
    for (int k = 0; k < len; k++)
      send_sample(ID_W'($urandom), pick_value(), pick_class(), k == len - 1);
    runs_sent++;
  endtask

  initial begin : stimulus
    int random_goal;
    int phase;
    int len;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: threshold 0, upper side kept, target class 0
    send_sample(16'hFFFF, '0, 8'h00, 1'b0);
    send_sample(16'h0000, FEAT_MAX, 8'hFF, 1'b0);
    send_sample(16'h5A5A, '1, 8'h00, 1'b1);         // last sample dropped
    send_sample(16'hA5A5, FEAT_MIN, 8'hFF, 1'b1);   // run with nothing kept
    runs_sent += 2;
    settle();

    // writes outside the register list must change nothing
    write_reg(REG_UNUSED, '1);
    write_reg(REG_TOP_INDEX, '1);
    set_rule(FEAT_MAX, 1'b0, 8'hFF);
    send_sample(16'h0001, FEAT_MAX, 8'hFF, 1'b0);
    send_sample(16'h0002, FEAT_MAX - 1, 8'hFF, 1'b0);
    send_sample(16'h0003, FEAT_MIN, 8'h00, 1'b1);
    runs_sent++;
    settle();

    // nothing is below the minimum
    set_rule(FEAT_MIN, 1'b0, 8'h00);
    send_sample(16'h0004, FEAT_MIN, 8'h00, 1'b1);
    send_sample(16'h0005, FEAT_MAX, 8'h00, 1'b0);
    send_sample(16'h0006, '0, 8'h00, 1'b1);
    runs_sent += 2;
    settle();

    set_rule(FEAT_MIN, 1'b1, 8'h80);
    send_sample(16'hFFFF, FEAT_MIN, 8'h80, 1'b1);   // full agreement, fidelity 1.0
    runs_sent++;
    settle();

    // threshold 1.5, values straddling it
    set_rule(32'h0001_8000, 1'b1, 8'h7F);
    send_sample(16'h0007, 32'h0001_7FFF, 8'h7F, 1'b0);
    send_sample(16'h0008, 32'h0001_8000, 8'h7F, 1'b0);
    send_sample(16'h0009, 32'h0001_8001, 8'h01, 1'b0);
    send_sample(16'h000A, 32'h7FFF_0000, 8'h7F, 1'b1);
    runs_sent++;

    random_goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < random_goal) begin
      settle();
      if (phase == HOLD_PHASE) begin
        // keep everything so the output backs up into the input
        set_rule(FEAT_MIN, 1'b1, CLASS_W'($urandom));
        hold_req <= 1'b1;
      end else begin
        set_rule(pick_threshold(), 1'(($urandom_range(0, 1))), CLASS_W'($urandom));
      end
      repeat ($urandom_range(2, 5)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
        send_run(len);
      end
      phase++;
    end

    settle();
    $display("covered %0d samples in %0d runs under %0d rule settings,", items_sent, runs_sent,
             rule_count);
    $display("with one long output stall backing up the input; %0d results compared",
             results_seen);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int   mode;
    int   span;
    logic held;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(posedge clk);
        if (hold_req && !held) begin
          held = 1'b1;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
